// ----- src/nksl_pkg.sv -----
// Package for the nearest-K sorted list: sizes, codes, payload types and helpers.
`timescale 1ns / 1ps

package nksl_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

  localparam int CODE_W  = 24;
  localparam int DIST_W  = 20;
  localparam int BEAR_W  = 12;
  localparam int RANK_W  = 4;
  localparam int LCNT_W  = 5;
  localparam int CAP_W   = 5;
  localparam int CFG_W   = 20;

  localparam logic [DIST_W-1:0] RANGE_RESET = DIST_W'(3200);
  localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(8);

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_OFFER = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_RANGE = 1'b0,
    CFG_CAP   = 1'b1
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHK,
    ST_INS,
    ST_READ
  } state_e;

  typedef struct packed {
    mode_e              mode;
    logic [CODE_W-1:0]  cand_code;
    logic [DIST_W-1:0]  cand_distance;
    logic [BEAR_W-1:0]  cand_bearing;
    logic               position_ok;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  out_code;
    logic [DIST_W-1:0]  out_distance;
    logic [BEAR_W-1:0]  out_bearing;
    logic [RANK_W-1:0]  out_slot;
    logic               out_present;
    logic               accepted;
    logic [LCNT_W-1:0]  list_count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [DIST_W-1:0]  distance;
    logic [BEAR_W-1:0]  bearing;
  } entry_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    entry_t             wdata;
    logic [SLOT_W-1:0]  raddr;
  } mem_req_t;

  // capacity register clipped to the number of physical slots
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] res;
    if (int'(cap) > MAX_SLOTS) begin
      res = CNT_W'(MAX_SLOTS);
    end else begin
      res = CNT_W'(cap);
    end
    return res;
  endfunction

endpackage

// ----- src/nksl_store.sv -----
// Slot store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module nksl_store (
  input  logic               clk_i,
  input  nksl_pkg::mem_req_t req_i,
  output nksl_pkg::entry_t   rdata_o
);

  nksl_pkg::entry_t mem_q [nksl_pkg::MAX_SLOTS];
  nksl_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/nksl_ctrl.sv -----
// Sequencer: range checks, one-slot-per-cycle insertion walk, readout and result register.
`timescale 1ns / 1ps

module nksl_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  nksl_pkg::in_item_t              item_i,
  input  logic [nksl_pkg::DIST_W-1:0]     max_range_i,
  input  logic [nksl_pkg::CAP_W-1:0]      cap_i,
  input  logic                            cap_we_i,
  input  logic [nksl_pkg::CAP_W-1:0]      cap_new_i,
  input  nksl_pkg::entry_t                rdata_i,
  output nksl_pkg::mem_req_t              req_o,
  output logic                            busy_o,
  output nksl_pkg::result_t               result_o,
  output logic                            result_valid_o
);

  nksl_pkg::state_e state_q, state_d;
  logic [nksl_pkg::CNT_W-1:0]  count_q, count_d;
  logic [nksl_pkg::SLOT_W-1:0] idx_q, idx_d;
  nksl_pkg::in_item_t          cand_q;
  nksl_pkg::result_t           res_q, res_d;
  logic                        res_vld_q, res_vld_d;

  logic [nksl_pkg::CNT_W-1:0]  cap_eff;
  logic [nksl_pkg::CNT_W-1:0]  cap_new_eff;
  logic                        accept;
  logic                        full;
  logic                        reject;
  logic                        chk_pass;
  logic                        ins_move;
  logic                        rd_last;

  assign accept      = start_i && (state_q == nksl_pkg::ST_IDLE);
  assign cap_eff     = nksl_pkg::eff_cap(cap_i);
  assign cap_new_eff = nksl_pkg::eff_cap(cap_new_i);
  assign full        = (count_q >= cap_eff);
  assign reject      = !item_i.position_ok || (max_range_i == '0) || (cap_eff == '0) ||
                       (item_i.cand_distance > max_range_i);
  assign chk_pass    = (cand_q.cand_distance < rdata_i.distance);
  assign ins_move    = (idx_q != '0) && (cand_q.cand_distance < rdata_i.distance);
  assign rd_last     = ((nksl_pkg::CNT_W'(idx_q) + nksl_pkg::CNT_W'(1)) == count_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nksl_pkg::ST_IDLE: begin
        if (accept) begin
          case (item_i.mode)
            nksl_pkg::MODE_OFFER: begin
              if (!reject) begin
                state_d = full ? nksl_pkg::ST_CHK : nksl_pkg::ST_INS;
              end
            end
            nksl_pkg::MODE_READ: begin
              if (count_q != '0) begin
                state_d = nksl_pkg::ST_READ;
              end
            end
            default: state_d = nksl_pkg::ST_IDLE;
          endcase
        end
      end
      nksl_pkg::ST_CHK:  state_d = chk_pass ? nksl_pkg::ST_INS : nksl_pkg::ST_IDLE;
      nksl_pkg::ST_INS:  state_d = ins_move ? nksl_pkg::ST_INS : nksl_pkg::ST_IDLE;
      nksl_pkg::ST_READ: state_d = rd_last  ? nksl_pkg::ST_IDLE : nksl_pkg::ST_READ;
      default:           state_d = nksl_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    res_vld_d = 1'b0;
    res_d     = '0;
    res_d.last = 1'b1;
    req_o     = '0;
    req_o.wdata = rdata_i;
    req_o.waddr = idx_q;

    case (state_q)
      nksl_pkg::ST_IDLE: begin
        if (accept) begin
          case (item_i.mode)
            nksl_pkg::MODE_CLEAR: begin
              count_d   = '0;
              res_vld_d = 1'b1;
            end
            nksl_pkg::MODE_OFFER: begin
              if (reject) begin
                res_vld_d = 1'b1;
              end else if (full) begin
                req_o.raddr = nksl_pkg::SLOT_W'(cap_eff - nksl_pkg::CNT_W'(1));
              end else begin
                idx_d       = nksl_pkg::SLOT_W'(count_q);
                req_o.raddr = nksl_pkg::SLOT_W'(count_q - nksl_pkg::CNT_W'(1));
                count_d     = count_q + nksl_pkg::CNT_W'(1);
              end
            end
            nksl_pkg::MODE_READ: begin
              if (count_q == '0) begin
                res_vld_d = 1'b1;
              end else begin
                idx_d       = '0;
                req_o.raddr = '0;
              end
            end
            default: res_vld_d = 1'b1;
          endcase
        end
      end
      nksl_pkg::ST_CHK: begin
        if (chk_pass) begin
          // the last entry is dropped; walk starts from the last slot
          idx_d       = nksl_pkg::SLOT_W'(cap_eff - nksl_pkg::CNT_W'(1));
          req_o.raddr = nksl_pkg::SLOT_W'(cap_eff - nksl_pkg::CNT_W'(2));
        end else begin
          res_vld_d = 1'b1;
        end
      end
      nksl_pkg::ST_INS: begin
        req_o.we = 1'b1;
        if (ins_move) begin
          idx_d       = idx_q - nksl_pkg::SLOT_W'(1);
          req_o.raddr = idx_q - nksl_pkg::SLOT_W'(2);
        end else begin
          req_o.wdata.code     = cand_q.cand_code;
          req_o.wdata.distance = cand_q.cand_distance;
          req_o.wdata.bearing  = cand_q.cand_bearing;
          res_vld_d            = 1'b1;
          res_d.accepted       = 1'b1;
        end
      end
      nksl_pkg::ST_READ: begin
        res_vld_d          = 1'b1;
        res_d.out_code     = rdata_i.code;
        res_d.out_distance = rdata_i.distance;
        res_d.out_bearing  = rdata_i.bearing;
        res_d.out_slot     = nksl_pkg::RANK_W'(idx_q);
        res_d.out_present  = 1'b1;
        res_d.last         = rd_last;
        if (!rd_last) begin
          idx_d       = idx_q + nksl_pkg::SLOT_W'(1);
          req_o.raddr = idx_q + nksl_pkg::SLOT_W'(1);
        end
      end
      default: begin
        res_vld_d = 1'b0;
      end
    endcase

    // lowering the capacity drops entries beyond it
    if (cap_we_i && (count_q > cap_new_eff)) begin
      count_d = cap_new_eff;
    end

    res_d.list_count = nksl_pkg::LCNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nksl_pkg::ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cand_q <= item_i;
    end
    res_q <= res_d;
  end

  assign busy_o         = (state_q != nksl_pkg::ST_IDLE);
  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

`ifndef ASSERT_OFF
  a_rank_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.out_present |->
      (nksl_pkg::LCNT_W'(res_q.out_slot) < res_q.list_count))
    else $error("readout rank beyond list count");

  a_ins_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nksl_pkg::ST_INS) && !ins_move |=> res_vld_q && res_q.accepted)
    else $error("finished insertion gave no accepted transaction");

  a_read_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.mode == nksl_pkg::MODE_READ) && (count_q != '0) |=>
      (state_q == nksl_pkg::ST_READ))
    else $error("readout of a nonempty list did not start");

  a_write_in_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.we |-> (state_q == nksl_pkg::ST_INS))
    else $error("slot write outside insertion");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nksl_pkg::ST_IDLE) |-> (count_q <= cap_eff) || $past(cap_we_i))
    else $error("entry count above capacity");
`endif

endmodule

// ----- src/nearest_k_sorted_list.sv -----
// Top level of the nearest-K sorted list: configuration registers, sequencer and slot store.
`timescale 1ns / 1ps

// Keeps up to 16 candidates sorted by ascending distance. An item is taken when start_i is
// high and busy_o is low; every result shows on result_o for one cycle with result_valid_o
// high and must be captured then, since the receiver cannot stall the block. A clear, an
// unused mode, a read of an empty list or an offer that fails the position, range or
// capacity checks gives its result in the cycle after acceptance and does not raise busy_o.
// An offer dropped from a full list for not being nearer than the last entry holds busy_o
// for one cycle. An offer that enters the list holds busy_o while it walks: one step for
// each entry it moves past, then one step that writes it; into a full list a check step
// comes first. A readout of n entries gives n results, one per cycle, and holds busy_o
// while it reads them. The insertion walk moves one slot per cycle through the slot
// store's single read port.
module nearest_k_sorted_list (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  nksl_pkg::in_item_t             item_i,
  output nksl_pkg::result_t              result_o,
  output logic                           result_valid_o,
  input  logic                           cfg_we_i,
  input  nksl_pkg::cfg_e                 cfg_idx_i,
  input  logic [nksl_pkg::CFG_W-1:0]     cfg_wdata_i
);

  logic [nksl_pkg::DIST_W-1:0] max_range_q;
  logic [nksl_pkg::CAP_W-1:0]  cap_q;
  logic                        range_we;
  logic                        cap_we;
  nksl_pkg::mem_req_t          mem_req;
  nksl_pkg::entry_t            mem_rdata;

  assign range_we = cfg_we_i && (cfg_idx_i == nksl_pkg::CFG_RANGE);
  assign cap_we   = cfg_we_i && (cfg_idx_i == nksl_pkg::CFG_CAP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_range_q <= nksl_pkg::RANGE_RESET;
      cap_q       <= nksl_pkg::CAP_RESET;
    end else begin
      if (range_we) begin
        max_range_q <= nksl_pkg::DIST_W'(cfg_wdata_i);
      end
      if (cap_we) begin
        cap_q <= nksl_pkg::CAP_W'(cfg_wdata_i);
      end
    end
  end

  nksl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .max_range_i    (max_range_q),
    .cap_i          (cap_q),
    .cap_we_i       (cap_we),
    .cap_new_i      (nksl_pkg::CAP_W'(cfg_wdata_i)),
    .rdata_i        (mem_rdata),
    .req_o          (mem_req),
    .busy_o         (busy_o),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  nksl_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the nearest-K sorted list: directed and random offers, reads, clears.
`timescale 1ns / 1ps

module testbench;

  // Tracks the sorted list the block should hold and the results still owed by it.
  class nearest_list_tracker;
    nksl_pkg::entry_t            slots [nksl_pkg::MAX_SLOTS];
    int unsigned                 held;
    logic [nksl_pkg::DIST_W-1:0] range_limit;
    logic [nksl_pkg::CAP_W-1:0]  cap_reg;
    nksl_pkg::result_t           pending_results [$];
    int unsigned                 fail_count;

    function new();
      foreach (slots[i]) slots[i] = '0;
      held        = 0;
      range_limit = nksl_pkg::RANGE_RESET;
      cap_reg     = nksl_pkg::CAP_RESET;
      fail_count  = 0;
    endfunction

    function int unsigned usable_slots();
      return (cap_reg > nksl_pkg::MAX_SLOTS) ? nksl_pkg::MAX_SLOTS : cap_reg;
    endfunction

    function void write_reg(nksl_pkg::cfg_e idx, logic [nksl_pkg::CFG_W-1:0] val);
      int unsigned lim;
      if (idx == nksl_pkg::CFG_RANGE) begin
        range_limit = val[nksl_pkg::DIST_W-1:0];
      end else begin
        cap_reg = val[nksl_pkg::CAP_W-1:0];
        lim = usable_slots();
        // shrinking the capacity drops and zeroes the tail entries
        if (held > lim) begin
          for (int i = lim; i < held; i++) slots[i] = '0;
          held = lim;
        end
      end
    endfunction

    function void take_item(nksl_pkg::in_item_t it);
      nksl_pkg::result_t r;
      int unsigned       lim;
      int unsigned       pos;
      bit                taken;
      r      = '0;
      r.last = 1'b1;
      taken  = 1'b0;
      pos    = 0;
      case (it.mode)
        nksl_pkg::MODE_CLEAR: begin
          foreach (slots[i]) slots[i] = '0;
          held = 0;
        end
        nksl_pkg::MODE_OFFER: begin
          lim = usable_slots();
          if (it.position_ok && range_limit != 0 && lim != 0 &&
              it.cand_distance <= range_limit) begin
            if (held > lim) held = lim;
            if (held < lim) begin
              pos   = held;
              held  = held + 1;
              taken = 1'b1;
            end else if (it.cand_distance < slots[lim-1].distance) begin
              pos   = lim - 1;
              taken = 1'b1;
            end
            if (taken) begin
              // strict compare: equal distances stay behind older entries
              while (pos > 0 && it.cand_distance < slots[pos-1].distance) begin
                slots[pos] = slots[pos-1];
                pos--;
              end
              slots[pos].code     = it.cand_code;
              slots[pos].distance = it.cand_distance;
              slots[pos].bearing  = it.cand_bearing;
            end
          end
          r.accepted = taken;
        end
        nksl_pkg::MODE_READ: begin
          if (held != 0) begin
            for (int i = 0; i < held; i++) begin
              r.out_code     = slots[i].code;
              r.out_distance = slots[i].distance;
              r.out_bearing  = slots[i].bearing;
              r.out_slot     = nksl_pkg::RANK_W'(i);
              r.out_present  = 1'b1;
              r.list_count   = nksl_pkg::LCNT_W'(held);
              r.last         = (i == held - 1);
              pending_results.push_back(r);
            end
            return;
          end
        end
        default: ;
      endcase
      r.list_count = nksl_pkg::LCNT_W'(held);
      pending_results.push_back(r);
    endfunction

    function void field_cmp(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        fail_count++;
        $display("%0t  %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void compare_result(nksl_pkg::result_t got);
      nksl_pkg::result_t want;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t  unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      field_cmp("out_code",     want.out_code,     got.out_code);
      field_cmp("out_distance", want.out_distance, got.out_distance);
      field_cmp("out_bearing",  want.out_bearing,  got.out_bearing);
      field_cmp("out_slot",     want.out_slot,     got.out_slot);
      field_cmp("out_present",  want.out_present,  got.out_present);
      field_cmp("accepted",     want.accepted,     got.accepted);
      field_cmp("list_count",   want.list_count,   got.list_count);
      field_cmp("last",         want.last,         got.last);
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       start_i     = 1'b0;
  logic                       busy_o;
  nksl_pkg::in_item_t         item_i      = '0;
  nksl_pkg::result_t          result_o;
  logic                       result_valid_o;
  logic                       cfg_we_i    = 1'b0;
  nksl_pkg::cfg_e             cfg_idx_i   = nksl_pkg::CFG_RANGE;
  logic [nksl_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  nearest_list_tracker board = new();

  // per-phase register settings, extremes included
  int unsigned phase_range [7] = '{20'hFFFFF, 20'hFFFFF, 0, 50000, 100000, 1, 2000};
  int unsigned phase_cap   [7] = '{16, 5, 16, 0, 31, 1, 3};

  nearest_k_sorted_list dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      board.compare_result(result_o);
    end
  end

  function automatic nksl_pkg::in_item_t offer_item(int unsigned code, int unsigned range_val,
                                                    int unsigned bear, bit ok);
    nksl_pkg::in_item_t it;
    it.mode          = nksl_pkg::MODE_OFFER;
    it.cand_code     = nksl_pkg::CODE_W'(code);
    it.cand_distance = nksl_pkg::DIST_W'(range_val);
    it.cand_bearing  = nksl_pkg::BEAR_W'(bear);
    it.position_ok   = ok;
    return it;
  endfunction

  function automatic nksl_pkg::in_item_t rand_item(nksl_pkg::mode_e m);
    nksl_pkg::in_item_t it;
    int unsigned        lim;
    lim              = board.range_limit;
    it.mode          = m;
    it.cand_code     = nksl_pkg::CODE_W'($urandom);
    it.cand_bearing  = nksl_pkg::BEAR_W'($urandom_range(0, 3599));
    it.position_ok   = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 9))
      6:       it.cand_distance = nksl_pkg::DIST_W'(lim);
      7:       it.cand_distance = (lim == 20'hFFFFF) ? nksl_pkg::DIST_W'(lim)
                 : nksl_pkg::DIST_W'($urandom_range(lim + 1, 20'hFFFFF));
      8:       it.cand_distance = nksl_pkg::DIST_W'(lim / 2);  // repeats give ties
      9:       it.cand_distance = nksl_pkg::DIST_W'($urandom);
      default: it.cand_distance = nksl_pkg::DIST_W'($urandom_range(0, lim));
    endcase
    return it;
  endfunction

  // drive at the falling edge, hold until taken; returns at a falling edge with start high
  task automatic send_item(input nksl_pkg::in_item_t it);
    item_i  = it;
    start_i = 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.take_item(it);
    @(negedge clk_i);
  endtask

  task automatic sender_gap(input bit quiet);
    int unsigned n;
    n = 0;
    if (!quiet) begin
      case ($urandom_range(0, 9))
        5, 6, 7, 8: n = $urandom_range(1, 3);
        9:          n = $urandom_range(8, 40);
        default:    n = 0;
      endcase
    end
    if (n != 0) begin
      start_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic settle();
    start_i = 1'b0;
    while (board.pending_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input nksl_pkg::cfg_e idx, input int unsigned val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = nksl_pkg::CFG_W'(val);
    board.write_reg(idx, nksl_pkg::CFG_W'(val));
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  initial begin
    bit                 quiet;
    int unsigned        pick;
    nksl_pkg::in_item_t directed [$];

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: range 3200, eight slots
    directed.push_back(rand_item(nksl_pkg::MODE_READ));           // empty list
    directed.push_back(offer_item(24'h414243, 10, 100, 1'b0));    // bad position
    directed.push_back(offer_item(24'hFFFFFF, 3200, 3599, 1'b1)); // on the range limit
    directed.push_back(offer_item(24'h123456, 3201, 5, 1'b1));    // just past it
    directed.push_back(offer_item(24'h000000, 0, 0, 1'b1));
    directed.push_back(offer_item(24'h4E4531, 500, 900, 1'b1));
    directed.push_back(offer_item(24'h4E4532, 500, 1800, 1'b1));  // tie, stays behind
    directed.push_back(offer_item(24'h4E4533, 500, 2700, 1'b1));
    directed.push_back(offer_item(24'hABCDEF, 1000, 2047, 1'b1));
    directed.push_back(offer_item(24'h555555, 2000, 1234, 1'b1));
    directed.push_back(offer_item(24'hAAAAAA, 3000, 3000, 1'b1)); // list now full
    directed.push_back(offer_item(24'h313233, 3000, 11, 1'b1));   // evicts the last entry
    directed.push_back(offer_item(24'h343536, 3000, 22, 1'b1));   // ties the last: dropped
    directed.push_back(offer_item(24'h373839, 3100, 33, 1'b1));   // farther: dropped
    directed.push_back(offer_item(24'h7E7E7E, 1, 44, 1'b1));      // walks up to slot 1, behind the zero entry
    directed.push_back(rand_item(nksl_pkg::MODE_READ));
    directed.push_back(rand_item(nksl_pkg::MODE_NONE));
    directed.push_back(rand_item(nksl_pkg::MODE_READ));
    directed.push_back(rand_item(nksl_pkg::MODE_CLEAR));
    directed.push_back(rand_item(nksl_pkg::MODE_READ));
    foreach (directed[i]) begin
      send_item(directed[i]);
      sender_gap(1'b0);
    end

    for (int p = 0; p < 7; p++) begin
      settle();
      write_cfg(nksl_pkg::CFG_RANGE, phase_range[p]);
      write_cfg(nksl_pkg::CFG_CAP, phase_cap[p]);
      quiet = (p == 2) || ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        send_item(offer_item(24'hFFFFFF, 20'hFFFFF, 3599, 1'b1));
      end
      repeat (23) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_item(rand_item(nksl_pkg::MODE_OFFER));
        end else if (pick < 88) begin
          send_item(rand_item(nksl_pkg::MODE_READ));
        end else if (pick < 94) begin
          send_item(rand_item(nksl_pkg::MODE_CLEAR));
        end else begin
          send_item(rand_item(nksl_pkg::MODE_NONE));
        end
        sender_gap(quiet);
      end
    end
    send_item(rand_item(nksl_pkg::MODE_READ));
    start_i = 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.fail_count == 0 && board.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
src/nksl_pkg.sv
src/nksl_store.sv
src/nksl_ctrl.sv
src/nearest_k_sorted_list.sv
bench/testbench.sv
